// ===== rtl/vst_pkg.sv =====
// Shared types, constants and helpers for the voice segment tracker.
// Used by the stream interfaces and the core; depends on nothing else.

package vst_pkg;

  localparam int unsigned MaxWindow = 16;
  localparam int unsigned RingAw    = $clog2(MaxWindow);
  localparam int unsigned WinW      = $clog2(MaxWindow) + 1;
  localparam int unsigned SumW      = 16 + RingAw;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgThreshold  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowLen  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHopSamples = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLookBehind = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxSegment = 3'd4;

  // Commands.
  localparam logic [1:0] CmdHop   = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdStop  = 2'd2;

  // Events.
  localparam logic [1:0] EvNone     = 2'd0;
  localparam logic [1:0] EvStart    = 2'd1;
  localparam logic [1:0] EvContinue = 2'd2;
  localparam logic [1:0] EvEnd      = 2'd3;

  localparam logic [47:0] SeenMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] LenMax  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] voice_probability;
  } vst_in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [47:0] segment_start_sample;
    logic [47:0] segment_end_sample;
    logic [31:0] segment_length;
    logic        is_voice;
  } vst_out_t;

  // Window length as used: zero acts as one, oversize values clamp.
  function automatic logic [WinW-1:0] eff_window(input logic [4:0] wl);
    logic [WinW-1:0] r;
    if (wl == 5'd0) begin
      r = WinW'(1);
    end else if ({{(32-5){1'b0}}, wl} > MaxWindow) begin
      r = WinW'(MaxWindow);
    end else begin
      r = WinW'(wl);
    end
    return r;
  endfunction

endpackage

// ===== rtl/vst_in_if.sv =====
// Request channel carrying commands into the voice segment tracker.
// Depends on vst_pkg for the payload type.

interface vst_in_if import vst_pkg::*; ();
  logic    valid;
  logic    ready;
  vst_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/vst_out_if.sv =====
// Request channel carrying segment events out of the voice segment tracker.
// Depends on vst_pkg for the payload type.

interface vst_out_if import vst_pkg::*; ();
  logic     valid;
  logic     ready;
  vst_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/vst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the probability ring of the tracker.

module vst_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/voice_segment_tracker_core.sv =====
// Voice segment tracker: smooths per-hop voice probabilities over a ring of up to
// 16 entries and reports segment start, continue and end events with sample
// positions. It accepts one request per cycle unless output backpressure or a window
// rebuild holds it off, and returns one result per request via the s1 and output
// registers; the ring lives in a RAM that is read when a hop enters and written back
// from the s1 stage, with forwarding when consecutive hops hit the same slot. After a
// write to window_len the running sum is rebuilt by reading the window slots one per
// cycle, so input is held off until the effective window length (zero counts as one,
// anything above 16 as 16) is summed. Depends on vst_pkg, vst_in_if, vst_out_if, vst_ram.

module voice_segment_tracker_core import vst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  vst_in_if.sink              in_i,
  vst_out_if.source           out_o
);

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       prob;
    logic              hop;       // hop while the session is active
    logic              wr;        // hop that writes the ring
    logic [RingAw-1:0] addr;
    logic              old_vld;
    logic              byp;
    logic [15:0]       byp_data;
  } s1_t;

  // Configuration registers.
  logic [15:0] threshold_q;
  logic [4:0]  window_len_q;
  logic [12:0] hop_samples_q;
  logic [15:0] look_behind_q;
  logic [31:0] max_segment_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= 16'd32768;
      window_len_q  <= 5'd8;
      hop_samples_q <= 13'd256;
      look_behind_q <= 16'd8192;
      max_segment_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold:  threshold_q   <= cfg_wdata_i[15:0];
        CfgWindowLen:  window_len_q  <= cfg_wdata_i[4:0];
        CfgHopSamples: hop_samples_q <= cfg_wdata_i[12:0];
        CfgLookBehind: look_behind_q <= cfg_wdata_i[15:0];
        CfgMaxSegment: max_segment_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  logic [WinW-1:0] wl;
  assign wl = eff_window(window_len_q);

  // Pipeline control.
  logic enable;
  logic accept;
  logic s1_valid_q, s1_valid_d;
  s1_t  s1_q, s1_d;
  logic out_valid_q;
  vst_out_t out_q, out_d;

  logic sweep_busy_q, sweep_busy_d;
  logic [WinW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic sweep_pend_q, sweep_pend_d;
  logic sweep_vld_q, sweep_vld_d;
  logic sweep_issue;

  assign enable      = !out_valid_q || out_o.ready;
  assign in_i.ready  = enable && !sweep_busy_q;
  assign accept      = in_i.valid && in_i.ready;
  assign sweep_issue = sweep_busy_q && (sweep_cnt_q < wl);

  // Front-end state: session flag and ring write pointer.
  logic              active_q, active_d;
  logic [RingAw-1:0] ring_index_q, ring_index_d;
  logic [RingAw-1:0] idx;
  logic [RingAw-1:0] idx_next;
  logic              in_hop, in_wr;

  // Ring storage.
  logic [MaxWindow-1:0] ring_vld_q, ring_vld_d;
  logic                 ram_we, ram_re;
  logic [RingAw-1:0]    ram_raddr;
  logic [15:0]          ram_rdata;

  assign in_hop = (in_i.payload.cmd == CmdHop) && active_q;
  assign in_wr  = in_hop && (threshold_q != 16'd0);
  assign idx    = ({1'b0, ring_index_q} < wl) ? ring_index_q : '0;
  assign idx_next = ((WinW'(idx) + WinW'(1)) == wl) ? '0 : idx + RingAw'(1);

  assign ram_we    = s1_valid_q && s1_q.wr && enable;
  assign ram_re    = (accept && in_wr) || sweep_issue;
  assign ram_raddr = accept ? idx : sweep_cnt_q[RingAw-1:0];

  vst_ram #(
    .Width (16),
    .Depth (MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (s1_q.prob),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    active_d     = active_q;
    ring_index_d = ring_index_q;
    s1_valid_d   = s1_valid_q;
    s1_d         = s1_q;
    if (enable) begin
      s1_valid_d = accept;
    end
    if (accept) begin
      priority if (in_i.payload.cmd == CmdStart) begin
        active_d     = 1'b1;
        ring_index_d = '0;
      end else if (in_i.payload.cmd == CmdStop) begin
        active_d = 1'b0;
      end else if (in_wr) begin
        ring_index_d = idx_next;
      end
      s1_d.cmd      = in_i.payload.cmd;
      s1_d.prob     = in_i.payload.voice_probability;
      s1_d.hop      = in_hop;
      s1_d.wr       = in_wr;
      s1_d.addr     = idx;
      s1_d.old_vld  = ring_vld_q[idx];
      // The slot being written back this cycle is read before the write lands.
      s1_d.byp      = ram_we && (s1_q.addr == idx);
      s1_d.byp_data = s1_q.prob;
    end
  end

  // Execute stage: running sum, voice decision and segment bookkeeping.
  logic        prev_voice_q, prev_voice_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [47:0] seen_q, seen_d;
  logic [31:0] len_q, len_d;

  logic [15:0]     old_prob;
  logic [SumW-1:0] sum_upd, sum_n;
  logic [48:0]     seen_sum;
  logic [47:0]     seen_n;
  logic [32:0]     len_sum;
  logic [31:0]     len_inc, len_n, lb_len;
  logic [SumW:0]   thr_win;
  logic            voice;

  assign old_prob = s1_q.byp ? s1_q.byp_data : (s1_q.old_vld ? ram_rdata : 16'd0);
  assign sum_upd  = sum_q - SumW'(old_prob) + SumW'(s1_q.prob);
  assign sum_n    = s1_q.wr ? sum_upd : sum_q;
  assign thr_win  = (SumW+1)'(threshold_q) * (SumW+1)'(wl);
  assign seen_sum = {1'b0, seen_q} + 49'(hop_samples_q);
  assign seen_n   = seen_sum[48] ? SeenMax : seen_sum[47:0];
  assign len_sum  = {1'b0, len_q} + 33'(hop_samples_q);
  assign len_inc  = len_sum[32] ? LenMax : len_sum[31:0];
  assign lb_len   = (48'(look_behind_q) < seen_n) ? 32'(look_behind_q) : seen_n[31:0];

  always_comb begin
    voice = (threshold_q == 16'd0) || ({1'b0, sum_n} > thr_win);
    if ((max_segment_q != 32'd0) && (len_q > max_segment_q)) begin
      voice = 1'b0;
    end
  end

  always_comb begin
    seen_d       = seen_q;
    len_d        = len_q;
    prev_voice_d = prev_voice_q;
    sum_d        = sum_q;
    len_n        = len_q;
    out_d        = '0;
    sweep_busy_d = sweep_busy_q;
    sweep_cnt_d  = sweep_cnt_q;
    sweep_pend_d = 1'b0;
    sweep_vld_d  = sweep_vld_q;
    ring_vld_d   = ring_vld_q;

    if (ram_we) begin
      ring_vld_d[s1_q.addr] = 1'b1;
    end

    if (s1_valid_q && enable) begin
      priority if (s1_q.cmd == CmdStart) begin
        seen_d       = '0;
        len_d        = '0;
        prev_voice_d = 1'b0;
      end else if (s1_q.cmd == CmdStop) begin
        if (prev_voice_q) begin
          out_d.event_res          = EvEnd;
          out_d.segment_end_sample = seen_q;
          out_d.segment_length     = len_q;
          prev_voice_d             = 1'b0;
          len_d                    = '0;
        end
      end else if (s1_q.hop) begin
        seen_d = seen_n;
        sum_d  = sum_n;
        priority if (voice && !prev_voice_q) begin
          len_n           = lb_len;
          out_d.event_res = EvStart;
        end else if (!voice && prev_voice_q) begin
          len_n           = len_inc;
          out_d.event_res = EvEnd;
        end else if (voice && prev_voice_q) begin
          len_n           = len_inc;
          out_d.event_res = EvContinue;
        end
        if (out_d.event_res != EvNone) begin
          out_d.segment_end_sample = seen_n;
          out_d.segment_length     = len_n;
          out_d.is_voice           = voice;
        end
        len_d        = (out_d.event_res == EvEnd) ? 32'd0 : len_n;
        prev_voice_d = voice;
      end
    end

    // Rebuild the running sum over the new window, one slot per cycle.
    if (cfg_we_i && (cfg_idx_i == CfgWindowLen)) begin
      sweep_busy_d = 1'b1;
      sweep_cnt_d  = '0;
      sum_d        = '0;
    end else begin
      if (sweep_pend_q) begin
        sum_d = sum_q + (sweep_vld_q ? SumW'(ram_rdata) : SumW'(0));
      end
      if (sweep_issue) begin
        sweep_cnt_d  = sweep_cnt_q + WinW'(1);
        sweep_pend_d = 1'b1;
        sweep_vld_d  = ring_vld_q[sweep_cnt_q[RingAw-1:0]];
      end else if (sweep_busy_q && !sweep_pend_q) begin
        sweep_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      ring_index_q <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_voice_q <= 1'b0;
      sum_q        <= '0;
      seen_q       <= '0;
      len_q        <= '0;
      ring_vld_q   <= '0;
      sweep_busy_q <= 1'b0;
      sweep_cnt_q  <= '0;
      sweep_pend_q <= 1'b0;
      sweep_vld_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      ring_index_q <= ring_index_d;
      s1_valid_q   <= s1_valid_d;
      if (enable) begin
        out_valid_q <= s1_valid_q;
      end
      prev_voice_q <= prev_voice_d;
      sum_q        <= sum_d;
      seen_q       <= seen_d;
      len_q        <= len_d;
      ring_vld_q   <= ring_vld_d;
      sweep_busy_q <= sweep_busy_d;
      sweep_cnt_q  <= sweep_cnt_d;
      sweep_pend_q <= sweep_pend_d;
      sweep_vld_q  <= sweep_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (enable && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  // The start position is derived from the registered end position and length.
  logic [47:0] start_sample;
  assign start_sample = (out_q.segment_end_sample >= 48'(out_q.segment_length))
                      ? out_q.segment_end_sample - 48'(out_q.segment_length)
                      : 48'd0;

  assign out_o.valid                        = out_valid_q;
  assign out_o.payload.event_res            = out_q.event_res;
  assign out_o.payload.segment_start_sample = start_sample;
  assign out_o.payload.segment_end_sample   = out_q.segment_end_sample;
  assign out_o.payload.segment_length       = out_q.segment_length;
  assign out_o.payload.is_voice             = out_q.is_voice;

endmodule
